// ===== src/atom_contact_filter_defines.svh =====
// Assertion macros shared by the contact filter modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ATOM_CONTACT_FILTER_DEFINES_SVH
`define ATOM_CONTACT_FILTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ACF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atom contact filter: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ACF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atom contact filter: next-cycle check failed");

`endif

// ===== src/acf_pkg.sv =====
// Package for the atom contact filter: widths, constants, codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package acf_pkg;

    localparam int ACF_COORD_W = 20;
    localparam int ACF_RAD_W   = 12;
    localparam int ACF_CUT_W   = 16;
    localparam int ACF_LIM_W   = 2 * ACF_CUT_W;
    localparam int ACF_MAG_W   = ACF_COORD_W;
    localparam int ACF_SQ_W    = 2 * ACF_MAG_W;
    localparam int ACF_SUM_W   = ACF_SQ_W + 2;
    localparam int ACF_ENTRY_W = 3 * ACF_COORD_W;

    localparam int ACF_DEPTH   = 1024;
    localparam int ACF_ADDR_W  = $clog2(ACF_DEPTH);
    localparam int ACF_COUNT_W = $clog2(ACF_DEPTH + 1);

    // 1.5 A in units of 1/256 A.
    localparam logic [ACF_RAD_W-1:0] ACF_HEAVY_MIN    = 12'd384;
    // 5.0 A in units of 1/256 A.
    localparam logic [ACF_CUT_W-1:0] ACF_CUTOFF_RESET = 16'd1280;
    localparam logic [ACF_LIM_W-1:0] ACF_LIM_RESET    =
        ACF_LIM_W'(ACF_CUTOFF_RESET) * ACF_LIM_W'(ACF_CUTOFF_RESET);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } acf_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } acf_state_t;

    typedef struct packed {
        logic do_clear;
        logic do_load;
        logic start_query;
        logic issue;
        logic finish;
    } acf_cmd_t;

    typedef struct packed {
        logic scan_ok;
        logic last_addr;
        logic pipe_empty;
        logic out_free;
    } acf_status_t;

endpackage

// ===== src/acf_if.sv =====
// Valid/ready channel interfaces for the contact filter's input and result items.
// Depends on acf_pkg for the field widths.
`timescale 1ns / 1ps

interface acf_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              opcode;
    logic signed [acf_pkg::ACF_COORD_W-1:0]  pos_x;
    logic signed [acf_pkg::ACF_COORD_W-1:0]  pos_y;
    logic signed [acf_pkg::ACF_COORD_W-1:0]  pos_z;
    logic [acf_pkg::ACF_RAD_W-1:0]           atom_radius;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, atom_radius, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, atom_radius, output ready);
endinterface

interface acf_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    in_contact;
    logic signed [acf_pkg::ACF_COORD_W-1:0]  out_x;
    logic signed [acf_pkg::ACF_COORD_W-1:0]  out_y;
    logic signed [acf_pkg::ACF_COORD_W-1:0]  out_z;

    modport source (output valid, in_contact, out_x, out_y, out_z, input ready);
    modport sink   (input valid, in_contact, out_x, out_y, out_z, output ready);
endinterface

// ===== src/acf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module acf_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/acf_ctrl.sv =====
// Controller state machine of the contact filter: accepts items and sequences
// the store scan of a query. Depends on acf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "atom_contact_filter_defines.svh"

module acf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_opcode,
    input  acf_pkg::acf_status_t status,
    output logic                 in_ready,
    output acf_pkg::acf_cmd_t    cmd
);

    acf_pkg::acf_state_t state_reg;
    acf_pkg::acf_state_t state_next;
    logic                accept;

    assign accept = in_valid && (state_reg == acf_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acf_pkg::ST_IDLE:
            begin
                if (accept && (in_opcode == acf_pkg::OP_QUERY))
                begin
                    // A light atom or an empty store needs no scan.
                    state_next = status.scan_ok ? acf_pkg::ST_SCAN : acf_pkg::ST_FINISH;
                end
            end
            acf_pkg::ST_SCAN:
            begin
                if (status.last_addr)
                begin
                    state_next = acf_pkg::ST_DRAIN;
                end
            end
            acf_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = acf_pkg::ST_FINISH;
                end
            end
            acf_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = acf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = acf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == acf_pkg::ST_IDLE);
        cmd             = '0;
        cmd.issue       = (state_reg == acf_pkg::ST_SCAN);
        cmd.finish      = (state_reg == acf_pkg::ST_FINISH) && status.out_free;
        if (accept)
        begin
            case (in_opcode)
                acf_pkg::OP_CLEAR: cmd.do_clear    = 1'b1;
                acf_pkg::OP_LOAD:  cmd.do_load     = 1'b1;
                acf_pkg::OP_QUERY: cmd.start_query = 1'b1;
                default:           cmd             = cmd;
            endcase
        end
    end

    `ACF_ASSERT_NEXT(a_scan_moves_on, state_reg == acf_pkg::ST_SCAN,
        state_reg == acf_pkg::ST_SCAN || state_reg == acf_pkg::ST_DRAIN)
    `ACF_ASSERT_NEXT(a_finish_waits, state_reg == acf_pkg::ST_FINISH && !status.out_free,
        state_reg == acf_pkg::ST_FINISH)

endmodule

// ===== src/acf_datapath.sv =====
// Datapath of the contact filter: partner store, count, cutoff, the distance
// pipeline and the result register. Depends on acf_pkg, acf_ram and the macro header.
`timescale 1ns / 1ps
`include "atom_contact_filter_defines.svh"

module acf_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  acf_pkg::acf_cmd_t                      cmd,
    output acf_pkg::acf_status_t                   status,
    input  logic signed [acf_pkg::ACF_COORD_W-1:0] in_pos_x,
    input  logic signed [acf_pkg::ACF_COORD_W-1:0] in_pos_y,
    input  logic signed [acf_pkg::ACF_COORD_W-1:0] in_pos_z,
    input  logic [acf_pkg::ACF_RAD_W-1:0]          in_radius,
    input  logic                                   cfg_we,
    input  logic [acf_pkg::ACF_CUT_W-1:0]          cfg_wdata,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   out_in_contact,
    output logic signed [acf_pkg::ACF_COORD_W-1:0] out_x,
    output logic signed [acf_pkg::ACF_COORD_W-1:0] out_y,
    output logic signed [acf_pkg::ACF_COORD_W-1:0] out_z
);

    localparam int CW = acf_pkg::ACF_COORD_W;

    // Magnitude of the difference of two signed coordinates; it always fits CW bits.
    function automatic logic [acf_pkg::ACF_MAG_W-1:0] abs_diff(
        input logic [CW-1:0] a,
        input logic [CW-1:0] b
    );
        logic [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        abs_diff = d[CW] ? acf_pkg::ACF_MAG_W'(-d) : d[CW-1:0];
    endfunction

    logic [acf_pkg::ACF_COUNT_W-1:0] count_reg;
    logic [acf_pkg::ACF_LIM_W-1:0]   lim_reg;
    logic [acf_pkg::ACF_ADDR_W-1:0]  rd_addr_reg;
    logic [CW-1:0]                   q_x_reg, q_y_reg, q_z_reg;
    logic                            q_heavy_reg;
    logic                            v1_reg, v2_reg, v3_reg;
    logic [acf_pkg::ACF_MAG_W-1:0]   mag_x_reg, mag_y_reg, mag_z_reg;
    logic [acf_pkg::ACF_SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic                            hit_any_reg;
    logic                            out_valid_reg;
    logic                            out_contact_reg;
    logic [CW-1:0]                   out_x_reg, out_y_reg, out_z_reg;

    logic                             in_heavy;
    logic                             full;
    logic                             ram_we;
    logic [acf_pkg::ACF_ENTRY_W-1:0]  ram_rdata;
    logic [acf_pkg::ACF_SUM_W-1:0]    dist_sq;
    logic                             in_reach;

    assign in_heavy = in_radius >= acf_pkg::ACF_HEAVY_MIN;
    assign full     = count_reg == acf_pkg::ACF_COUNT_W'(acf_pkg::ACF_DEPTH);
    assign ram_we   = cmd.do_load && in_heavy && !full;

    acf_ram #(
        .WIDTH (acf_pkg::ACF_ENTRY_W),
        .DEPTH (acf_pkg::ACF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[acf_pkg::ACF_ADDR_W-1:0]),
        .wdata ({in_pos_z, in_pos_y, in_pos_x}),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign dist_sq  = acf_pkg::ACF_SUM_W'(sq_x_reg) + acf_pkg::ACF_SUM_W'(sq_y_reg)
                    + acf_pkg::ACF_SUM_W'(sq_z_reg);
    assign in_reach = dist_sq <= acf_pkg::ACF_SUM_W'(lim_reg);

    // Control state: count, cutoff, scan address, query heavy flag, pipeline valids, hit flag and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lim_reg       <= acf_pkg::ACF_LIM_RESET;
            rd_addr_reg   <= '0;
            q_heavy_reg   <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            hit_any_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lim_reg <= acf_pkg::ACF_LIM_W'(cfg_wdata) * acf_pkg::ACF_LIM_W'(cfg_wdata);
            end
            if (cmd.do_clear)
            begin
                count_reg <= '0;
            end
            else if (ram_we)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.start_query)
            begin
                rd_addr_reg <= '0;
                q_heavy_reg <= in_heavy;
                hit_any_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
                if (v3_reg && in_reach)
                begin
                    hit_any_reg <= 1'b1;
                end
            end

            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: query position, distance pipeline and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            q_x_reg <= in_pos_x;
            q_y_reg <= in_pos_y;
            q_z_reg <= in_pos_z;
        end
        mag_x_reg <= abs_diff(q_x_reg, ram_rdata[CW-1:0]);
        mag_y_reg <= abs_diff(q_y_reg, ram_rdata[2*CW-1:CW]);
        mag_z_reg <= abs_diff(q_z_reg, ram_rdata[3*CW-1:2*CW]);
        sq_x_reg  <= mag_x_reg * mag_x_reg;
        sq_y_reg  <= mag_y_reg * mag_y_reg;
        sq_z_reg  <= mag_z_reg * mag_z_reg;
        if (cmd.finish)
        begin
            out_contact_reg <= hit_any_reg;
            out_x_reg       <= hit_any_reg ? q_x_reg : '0;
            out_y_reg       <= hit_any_reg ? q_y_reg : '0;
            out_z_reg       <= hit_any_reg ? q_z_reg : '0;
        end
    end

    always_comb
    begin
        status.scan_ok    = in_heavy && (count_reg != '0);
        status.last_addr  = (acf_pkg::ACF_COUNT_W'(rd_addr_reg) + 1'b1) == count_reg;
        status.pipe_empty = !(v1_reg || v2_reg || v3_reg);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_in_contact = out_contact_reg;
    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign out_z          = out_z_reg;

    `ACF_ASSERT_IMPL(a_count_bounded, 1'b1,
        count_reg <= acf_pkg::ACF_COUNT_W'(acf_pkg::ACF_DEPTH))
    `ACF_ASSERT_NEXT(a_full_load_ignored, cmd.do_load && full, $stable(count_reg))
    `ACF_ASSERT_IMPL(a_no_write_in_scan, cmd.issue, !ram_we)
    `ACF_ASSERT_IMPL(a_hit_needs_heavy, hit_any_reg, q_heavy_reg)

endmodule

// ===== src/atom_contact_filter.sv =====
// Atom contact filter: a partner store of up to 1024 heavy atoms searched for
// any atom within the cutoff of a heavy query atom. A clear or load item leaves
// the controller idle, so loads can stream at one item per cycle. A query holds
// the input while the store's single read port delivers one entry per cycle
// into a three-stage distance pipeline (difference, square, sum and compare),
// which is then drained before the result is registered. A light query atom
// or an empty store skips the scan and its pipeline. One result item, contact
// or no contact, follows each query; the next item is accepted while that
// result still waits in the output register. The store needs no clearing
// after reset; only entries below the count are read.
// Depends on acf_pkg, acf_if, acf_ctrl and acf_datapath.
`timescale 1ns / 1ps

module atom_contact_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    acf_in_if.sink                        in_ch,
    acf_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [acf_pkg::ACF_CUT_W-1:0] cfg_wdata
);

    acf_pkg::acf_cmd_t    cmd;
    acf_pkg::acf_status_t status;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_in_contact;
    logic signed [acf_pkg::ACF_COORD_W-1:0] out_x, out_y, out_z;

    acf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    acf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_pos_x       (in_ch.pos_x),
        .in_pos_y       (in_ch.pos_y),
        .in_pos_z       (in_ch.pos_z),
        .in_radius      (in_ch.atom_radius),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (out_valid),
        .out_ready      (out_ch.ready),
        .out_in_contact (out_in_contact),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z)
    );

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid;
    assign out_ch.in_contact = out_in_contact;
    assign out_ch.out_x      = out_x;
    assign out_ch.out_y      = out_y;
    assign out_ch.out_z      = out_z;

endmodule

// ===== tb/sv/atom_contact_filter_tb.sv =====
// Self-checking testbench for atom_contact_filter: drives clear, load, query and unused-opcode
// items, predicts every contact answer and compares it with each result item field by field.
// Depends on acf_pkg and the channel interfaces in acf_if.
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0]                             op;
    logic signed [acf_pkg::ACF_COORD_W-1:0] x;
    logic signed [acf_pkg::ACF_COORD_W-1:0] y;
    logic signed [acf_pkg::ACF_COORD_W-1:0] z;
    logic [acf_pkg::ACF_RAD_W-1:0]          radius;
} atom_item_t;

typedef struct {
    logic                                   hit;
    logic signed [acf_pkg::ACF_COORD_W-1:0] x;
    logic signed [acf_pkg::ACF_COORD_W-1:0] y;
    logic signed [acf_pkg::ACF_COORD_W-1:0] z;
} contact_answer_t;

class contact_book;
    localparam int          PARTNER_SLOTS = 1024;
    localparam int unsigned HEAVY_RADIUS  = 384;   // 1.5 A
    localparam int unsigned CUTOFF_RESET  = 1280;  // 5.0 A

    logic [59:0]     partner_mem [PARTNER_SLOTS];
    int unsigned     partner_total;
    logic [15:0]     cutoff;
    contact_answer_t due_contacts[$];
    int unsigned     mismatches;
    int unsigned     answers_seen;
    int unsigned     hits_seen;

    function new();
        partner_total = 0;
        cutoff        = CUTOFF_RESET;
        mismatches    = 0;
        answers_seen  = 0;
        hits_seen     = 0;
    endfunction

    // Squared distances are exact in 1/65536 A^2, so a 64-bit sum never overflows.
    function bit touches(atom_item_t q, logic [59:0] entry);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(q.x)) - longint'($signed(entry[19:0]));
        dy = longint'($signed(q.y)) - longint'($signed(entry[39:20]));
        dz = longint'($signed(q.z)) - longint'($signed(entry[59:40]));
        return (dx * dx + dy * dy + dz * dz) <= (longint'(cutoff) * longint'(cutoff));
    endfunction

    function void note_item(atom_item_t it);
        contact_answer_t ans;
        ans.hit = 1'b0;
        ans.x   = '0;
        ans.y   = '0;
        ans.z   = '0;
        case (it.op)
            acf_pkg::OP_CLEAR:
                partner_total = 0;
            acf_pkg::OP_LOAD:
                if (it.radius >= HEAVY_RADIUS && partner_total < PARTNER_SLOTS)
                begin
                    partner_mem[partner_total] = {it.z, it.y, it.x};
                    partner_total++;
                end
            acf_pkg::OP_QUERY:
            begin
                if (it.radius >= HEAVY_RADIUS)
                begin
                    for (int i = 0; i < partner_total && !ans.hit; i++)
                    begin
                        if (touches(it, partner_mem[i]))
                        begin
                            ans.hit = 1'b1;
                            ans.x   = it.x;
                            ans.y   = it.y;
                            ans.z   = it.z;
                        end
                    end
                end
                due_contacts.insert(due_contacts.size(), ans);
            end
            default: ;
        endcase
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_answer(logic hit, logic signed [19:0] x, logic signed [19:0] y,
                      logic signed [19:0] z);
        contact_answer_t want;
        if (due_contacts.size() == 0)
        begin
            report_mismatch($sformatf("result item (contact %0b) with no query waiting", hit));
            return;
        end
        want = due_contacts.pop_front();
        answers_seen++;
        if (hit === 1'b1)
            hits_seen++;
        if (hit !== want.hit)
            report_mismatch($sformatf("in_contact %0b, expected %0b", hit, want.hit));
        if (x !== want.x)
            report_mismatch($sformatf("out_x %0d, expected %0d", x, want.x));
        if (y !== want.y)
            report_mismatch($sformatf("out_y %0d, expected %0d", y, want.y));
        if (z !== want.z)
            report_mismatch($sformatf("out_z %0d, expected %0d", z, want.z));
    endtask
endclass

module atom_contact_filter_tb;

    localparam logic [1:0]         OP_UNUSED     = 2'd3;
    localparam logic signed [19:0] COORD_MAX     = 20'sh7FFFF;
    localparam logic signed [19:0] COORD_MIN     = 20'sh80000;
    localparam int                 SETTLE_CYCLES = 12;
    localparam int                 FILL_LOADS    = 160;
    localparam int                 RANDOM_ITEMS  = 330;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    acf_in_if  in_bus ();
    acf_out_if res_bus ();

    atom_contact_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_bus),
        .out_ch    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    contact_book book;
    logic [59:0] placed[$];
    int unsigned cut_now = 1280;
    bit          steady_run = 1'b0;
    int          items_sent = 0;
    int          n_clear = 0;
    int          n_load = 0;
    int          n_query = 0;
    int          n_unused = 0;
    int          n_cutoffs = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check each accepted item, then stall now and then.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_bus.valid && res_bus.ready)
                book.check_answer(res_bus.in_contact, res_bus.out_x, res_bus.out_y,
                                  res_bus.out_z);
            res_bus.ready <= steady_run || ($urandom_range(99) >= 12);
        end
    end

    function automatic logic signed [19:0] rand_coord();
        return 20'($urandom());
    endfunction

    function automatic logic signed [19:0] near(logic signed [19:0] base, int unsigned span);
        int off;
        off = int'($urandom_range(2 * span)) - int'(span);
        return 20'(int'(base) + off);
    endfunction

    function automatic logic [11:0] heavy_radius();
        return 12'($urandom_range(4095, 384));
    endfunction

    function automatic logic [11:0] light_radius();
        return 12'($urandom_range(383));
    endfunction

    task automatic send_item(input logic [1:0] op, input logic signed [19:0] x,
                             input logic signed [19:0] y, input logic signed [19:0] z,
                             input logic [11:0] radius);
        atom_item_t it;
        it.op     = op;
        it.x      = x;
        it.y      = y;
        it.z      = z;
        it.radius = radius;
        while (!steady_run && $urandom_range(99) < 12)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.opcode      <= op;
        in_bus.pos_x       <= x;
        in_bus.pos_y       <= y;
        in_bus.pos_z       <= z;
        in_bus.atom_radius <= radius;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        book.note_item(it);
        case (op)
            acf_pkg::OP_CLEAR: n_clear++;
            acf_pkg::OP_LOAD:  n_load++;
            acf_pkg::OP_QUERY: n_query++;
            default:           n_unused++;
        endcase
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Loads leave no result behind, so a short settle follows the last answer.
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        while (book.due_contacts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cutoff(input logic [15:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        book.cutoff = value;
        cut_now     = value;
        n_cutoffs++;
    endtask

    task automatic run_directed();
        // Empty store, then a light partner that must not be stored.
        send_item(acf_pkg::OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 12'd4095);
        send_item(acf_pkg::OP_LOAD, 20'sd0, 20'sd0, 20'sd0, 12'd383);
        send_item(acf_pkg::OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 12'd384);
        send_item(acf_pkg::OP_LOAD, 20'sd0, 20'sd0, 20'sd0, 12'd384);
        // Exactly on the 5 A cutoff, then one step beyond it.
        send_item(acf_pkg::OP_QUERY, 20'sd1280, 20'sd0, 20'sd0, 12'd384);
        send_item(acf_pkg::OP_QUERY, 20'sd1281, 20'sd0, 20'sd0, 12'd384);
        send_item(acf_pkg::OP_QUERY, 20'sd0, 20'sd0, -20'sd1280, 12'd4095);
        send_item(acf_pkg::OP_QUERY, -20'sd905, -20'sd905, 20'sd0, 12'd2000);
        // A light query atom never reports contact.
        send_item(acf_pkg::OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 12'd383);
        send_item(OP_UNUSED, 20'sd0, 20'sd0, 20'sd0, 12'd4095);
        send_item(acf_pkg::OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, 12'd4095);
        send_item(acf_pkg::OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 12'd4095);
        send_item(acf_pkg::OP_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, 12'd2048);
        send_item(acf_pkg::OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN + 20'sd1280, 12'd400);
        send_item(acf_pkg::OP_QUERY, COORD_MAX, COORD_MIN, 20'sd0, 12'd4095);
        send_item(acf_pkg::OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 12'd0);
        send_item(acf_pkg::OP_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX, 12'd4095);
        send_item(acf_pkg::OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 12'd4095);
        send_item(acf_pkg::OP_LOAD, -20'sd1, -20'sd1, -20'sd1, 12'd1000);
        send_item(acf_pkg::OP_QUERY, -20'sd1, -20'sd1, -20'sd1, 12'd1000);
    endtask

    // With a zero cutoff only exact positions touch, so a heavy query must land
    // precisely on a stored atom to find it, first and last entry alike.
    task automatic fill_store();
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [59:0]        first_atom;
        logic [59:0]        last_atom;
        send_item(acf_pkg::OP_CLEAR, 20'sd0, 20'sd0, 20'sd0, 12'd0);
        placed.delete();
        steady_run = 1'b1;
        for (int i = 0; i < FILL_LOADS; i++)
        begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            send_item(acf_pkg::OP_LOAD, x, y, z, heavy_radius());
            if (i == 0)
                first_atom = {z, y, x};
            if (i == FILL_LOADS - 1)
                last_atom = {z, y, x};
        end
        steady_run = 1'b0;
        send_item(acf_pkg::OP_QUERY, last_atom[19:0], last_atom[39:20], last_atom[59:40],
                  heavy_radius());
        send_item(acf_pkg::OP_QUERY, first_atom[19:0], first_atom[39:20], first_atom[59:40],
                  heavy_radius());
        send_item(acf_pkg::OP_QUERY, last_atom[19:0], last_atom[39:20], last_atom[59:40],
                  light_radius());
        send_item(acf_pkg::OP_QUERY, last_atom[19:0] + 20'sd1, last_atom[39:20],
                  last_atom[59:40], heavy_radius());
        send_item(acf_pkg::OP_QUERY, rand_coord(), rand_coord(), rand_coord(), heavy_radius());
    endtask

    // One sequence: an optional clear, a cluster of partner loads with occasional
    // unused-opcode items, then queries that mostly land near a stored atom.
    task automatic run_batch(input int loads, input int queries);
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic signed [19:0] cz;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [59:0]        pick;
        int unsigned        span;
        int unsigned        kind;
        span = (cut_now * 4 + 256 > 200000) ? 200000 : cut_now * 4 + 256;
        cx   = rand_coord();
        cy   = rand_coord();
        cz   = rand_coord();
        if ($urandom_range(3) != 0)
        begin
            send_item(acf_pkg::OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                      12'($urandom()));
            placed.delete();
        end
        for (int i = 0; i < loads; i++)
        begin
            x = near(cx, span);
            y = near(cy, span);
            z = near(cz, span);
            if ($urandom_range(7) == 0)
                send_item(acf_pkg::OP_LOAD, x, y, z, light_radius());
            else
            begin
                send_item(acf_pkg::OP_LOAD, x, y, z, heavy_radius());
                placed.insert(placed.size(), {z, y, x});
            end
            if ($urandom_range(29) == 0)
                send_item(OP_UNUSED, rand_coord(), rand_coord(), rand_coord(), 12'($urandom()));
        end
        for (int q = 0; q < queries; q++)
        begin
            kind = $urandom_range(9);
            if (placed.size() == 0 || kind == 0)
            begin
                x = rand_coord();
                y = rand_coord();
                z = rand_coord();
            end
            else
            begin
                pick = placed[$urandom_range(placed.size() - 1)];
                x    = near(pick[19:0], cut_now);
                y    = near(pick[39:20], cut_now);
                z    = near(pick[59:40], cut_now);
                if (kind == 1)
                begin
                    // Sits exactly on the cutoff sphere along one axis.
                    x = 20'(int'($signed(pick[19:0])) + int'(cut_now));
                    y = pick[39:20];
                    z = pick[59:40];
                end
            end
            send_item(acf_pkg::OP_QUERY, x, y, z, (kind == 2) ? light_radius() : heavy_radius());
            if ($urandom_range(11) == 0)
            begin
                x = near(cx, span);
                y = near(cy, span);
                z = near(cz, span);
                send_item(acf_pkg::OP_LOAD, x, y, z, heavy_radius());
                placed.insert(placed.size(), {z, y, x});
            end
        end
    endtask

    initial
    begin
        int          phase;
        int          random_start;
        logic [15:0] setting;
        book               = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_bus.valid       = 1'b0;
        in_bus.opcode      = acf_pkg::OP_CLEAR;
        in_bus.pos_x       = '0;
        in_bus.pos_y       = '0;
        in_bus.pos_z       = '0;
        in_bus.atom_radius = '0;
        res_bus.ready      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        write_cutoff(16'd0);
        fill_store();

        phase        = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case (phase % 8)
                0:       setting = 16'd65535;
                1:       setting = 16'd1;
                2:       setting = 16'd1280;
                3:       setting = 16'($urandom());
                4:       setting = 16'd0;
                5:       setting = 16'd384;
                6:       setting = 16'($urandom_range(3000, 2));
                default: setting = 16'd4095;
            endcase
            write_cutoff(setting);
            steady_run = (phase == 2);
            repeat (3) run_batch($urandom_range(40, 1), $urandom_range(16, 4));
            steady_run = 1'b0;
            phase++;
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (book.due_contacts.size() != 0)
            book.report_mismatch($sformatf("%0d answers never arrived",
                                           book.due_contacts.size()));

        $display("Covered %0d loads, %0d queries, %0d clears and %0d unused-opcode items",
                 n_load, n_query, n_clear, n_unused);
        $display("under %0d cutoff settings; %0d answers checked, %0d of them contacts.",
                 n_cutoffs, book.answers_seen, book.hits_seen);
        if (book.mismatches == 0)
            $display("atom_contact_filter regression: pass");
        else
            $display("atom_contact_filter regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest legitimate run.
    initial
    begin
        #50_000_000;
        $display("atom_contact_filter regression: fail");
        $finish;
    end

endmodule

// ===== atom_contact_filter.f =====
+incdir+src
src/acf_pkg.sv
src/acf_if.sv
src/acf_ram.sv
src/acf_ctrl.sv
src/acf_datapath.sv
src/atom_contact_filter.sv
tb/sv/atom_contact_filter_tb.sv
